/* src/fgrt_pkg.sv */
// Shared types and constants for the FEC group receive tracker.
// Used by fgrt_step and fec_group_receive_tracker; depends on nothing.

package fgrt_pkg;

   localparam int MAX_SYMBOLS = 32;
   localparam int SYM_IDX_W   = $clog2(MAX_SYMBOLS);

   localparam int K_W = 5;
   localparam int N_W = 6;

   localparam logic [K_W-1:0] K_RESET = K_W'(4);
   localparam logic [N_W-1:0] N_RESET = N_W'(6);

   typedef enum logic [0:0] {
      CSR_SOURCE_COUNT = 1'b0,
      CSR_BLOCK_COUNT  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED     = 3'd0,
      ST_SHORT        = 3'd1,
      ST_STALE        = 3'd2,
      ST_BAD_SYMBOL   = 3'd3,
      ST_AFTER_REPAIR = 3'd4,
      ST_DUPLICATE    = 3'd5
   } status_type;

   typedef struct packed {
      logic        too_short;
      logic [15:0] header_group;
      logic [15:0] header_seq;
      logic [7:0]  header_symbol;
      logic [15:0] payload_size;
      logic        is_source;
   } item_type;

   typedef struct packed {
      logic [15:0]            current_group;
      logic [15:0]            highest_seq;
      logic [MAX_SYMBOLS-1:0] received_bits;
      logic [MAX_SYMBOLS-1:0] nonempty_bits;
      logic [7:0]             symbol_total;
      logic                   repaired_flag;
      logic [15:0]            max_size;
   } track_type;

   typedef struct packed {
      status_type             status;
      logic                   deliver_source;
      logic                   repair_request;
      logic [MAX_SYMBOLS-1:0] present_mask;
      logic [15:0]            longest_size;
      logic [15:0]            highest_seq_out;
   } result_type;

   function automatic logic wrap_negative(logic [15:0] a, logic [15:0] b);
      logic [15:0] diff;
      diff = a - b;
      return diff[15];
   endfunction

endpackage

/* src/fgrt_step.sv */
// Next-state and result logic of the tracker for one header transaction.
// Depends on fgrt_pkg.

module fgrt_step (
   input  fgrt_pkg::item_type         item,
   input  fgrt_pkg::track_type        track,
   input  logic [fgrt_pkg::K_W-1:0]   source_count,
   input  logic [fgrt_pkg::N_W-1:0]   block_count,
   output fgrt_pkg::track_type        track_next,
   output fgrt_pkg::result_type       result
);

   logic [fgrt_pkg::N_W-1:0]         n_eff;
   logic [fgrt_pkg::MAX_SYMBOLS-1:0] need;
   logic [fgrt_pkg::MAX_SYMBOLS-1:0] bit_sel;
   logic [fgrt_pkg::MAX_SYMBOLS-1:0] rcv_new;
   logic [7:0]                       total_new;
   fgrt_pkg::track_type              base;
   fgrt_pkg::status_type             status;
   logic                             deliver;
   logic                             repair;

   always_comb begin
      n_eff = (block_count > fgrt_pkg::N_W'(fgrt_pkg::MAX_SYMBOLS)) ?
              fgrt_pkg::N_W'(fgrt_pkg::MAX_SYMBOLS) : block_count;
      need = (fgrt_pkg::MAX_SYMBOLS'(1) << source_count) - fgrt_pkg::MAX_SYMBOLS'(1);
      bit_sel = fgrt_pkg::MAX_SYMBOLS'(1) << item.header_symbol[fgrt_pkg::SYM_IDX_W-1:0];

      base = track;
      if (item.header_group != track.current_group) begin
         base.current_group = item.header_group;
         base.received_bits = '0;
         base.nonempty_bits = '0;
         base.symbol_total  = '0;
         base.repaired_flag = 1'b0;
         base.max_size      = '0;
      end

      rcv_new   = base.received_bits | bit_sel;
      total_new = (base.symbol_total == 8'hFF) ? base.symbol_total
                                               : base.symbol_total + 8'd1;

      track_next = track;
      status     = fgrt_pkg::ST_ACCEPTED;
      deliver    = 1'b0;
      repair     = 1'b0;

      if (item.too_short) begin
         status = fgrt_pkg::ST_SHORT;
      end else if (item.header_group != track.current_group &&
                   fgrt_pkg::wrap_negative(item.header_group, track.current_group)) begin
         status  = fgrt_pkg::ST_STALE;
         deliver = item.is_source;
      end else begin
         track_next = base;
         if ({2'b00, item.header_symbol} >= {4'b0000, n_eff}) begin
            status = fgrt_pkg::ST_BAD_SYMBOL;
         end else if (base.repaired_flag) begin
            status = fgrt_pkg::ST_AFTER_REPAIR;
         end else begin
            if (fgrt_pkg::wrap_negative(base.highest_seq, item.header_seq)) begin
               track_next.highest_seq = item.header_seq;
            end
            if ((base.nonempty_bits & bit_sel) != '0) begin
               status = fgrt_pkg::ST_DUPLICATE;
            end else begin
               if (item.payload_size > base.max_size) begin
                  track_next.max_size = item.payload_size;
               end
               if (item.payload_size != 16'd0) begin
                  track_next.nonempty_bits = base.nonempty_bits | bit_sel;
               end
               track_next.received_bits = rcv_new;
               track_next.symbol_total  = total_new;
               deliver = item.is_source;
               if (total_new >= {3'b000, source_count} && (rcv_new & need) != need) begin
                  repair = 1'b1;
                  track_next.repaired_flag = 1'b1;
               end
            end
         end
      end

      result.status          = status;
      result.deliver_source  = deliver;
      result.repair_request  = repair;
      result.present_mask    = track_next.received_bits;
      result.longest_size    = track_next.max_size;
      result.highest_seq_out = track_next.highest_seq;
   end

endmodule

/* src/fec_group_receive_tracker.sv */
// Top level of the FEC group receive tracker; depends on fgrt_pkg and fgrt_step.
// An accepted request is held in the input register, its result in the result register.
// Throughput is one transaction per cycle while responses are taken; the tracking state
// is held here, updated as each item moves from the input to the result register.
// Reset is synchronous and active high; it empties both stages, clears the tracking
// state and sets source_count to 4 and block_count to 6.

module fec_group_receive_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // header_group, header_seq, header_symbol, payload_size
   input  logic [1:0]  req_tuser,  // too_short, is_source
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // deliver_source, repair_request, present_mask,
                                   // longest_size, highest_seq_out, zero fill
   output logic [2:0]  rsp_tuser,  // status
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [5:0]  csr_wdata
);

   logic                       in_valid_ff;
   fgrt_pkg::item_type         in_item_ff;
   logic                       out_valid_ff;
   fgrt_pkg::result_type       out_result_ff;
   fgrt_pkg::track_type        track_ff;
   fgrt_pkg::track_type        track_in;
   fgrt_pkg::result_type       result_in;
   logic [fgrt_pkg::K_W-1:0]   source_count_ff;
   logic [fgrt_pkg::N_W-1:0]   block_count_ff;
   fgrt_pkg::item_type         req_item;
   logic                       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      req_item.too_short     = req_tuser[0];
      req_item.is_source     = req_tuser[1];
      req_item.header_group  = req_tdata[15:0];
      req_item.header_seq    = req_tdata[31:16];
      req_item.header_symbol = req_tdata[39:32];
      req_item.payload_size  = req_tdata[55:40];
   end

   fgrt_step u_step (
      .item         (in_item_ff),
      .track        (track_ff),
      .source_count (source_count_ff),
      .block_count  (block_count_ff),
      .track_next   (track_in),
      .result       (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         track_ff        <= '0;
         source_count_ff <= fgrt_pkg::K_RESET;
         block_count_ff  <= fgrt_pkg::N_RESET;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            track_ff     <= track_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (fgrt_pkg::csr_index_type'(csr_addr))
               fgrt_pkg::CSR_SOURCE_COUNT: source_count_ff <= csr_wdata[fgrt_pkg::K_W-1:0];
               fgrt_pkg::CSR_BLOCK_COUNT:  block_count_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.status;
   assign rsp_tdata  = {6'd0,
                        out_result_ff.highest_seq_out,
                        out_result_ff.longest_size,
                        out_result_ff.present_mask,
                        out_result_ff.repair_request,
                        out_result_ff.deliver_source};

   // A repair request only comes with a newly accepted symbol.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_result_ff.repair_request |->
         out_result_ff.status == fgrt_pkg::ST_ACCEPTED)
      else $error("repair request on a rejected transaction");

   // Delivery happens only for accepted symbols or stale source packets.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_result_ff.deliver_source |->
         out_result_ff.status == fgrt_pkg::ST_ACCEPTED ||
         out_result_ff.status == fgrt_pkg::ST_STALE)
      else $error("source delivered on a rejected transaction");

   // Every symbol with a payload has also been marked as received.
   assert property (@(posedge clock) disable iff (reset)
      (track_ff.nonempty_bits & ~track_ff.received_bits) == '0)
      else $error("non-empty symbol not marked as received");

   // A group with no counted symbols has nothing received and no repair pending.
   assert property (@(posedge clock) disable iff (reset)
      track_ff.symbol_total == 8'd0 |->
         track_ff.received_bits == '0 && !track_ff.repaired_flag)
      else $error("symbol count out of step with the received bitmap");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for fec_group_receive_tracker: a directed table, then random groups.
// Each accepted packet header is run through a local tracker model and each response is checked.
// Depends on fgrt_pkg and the RTL of fec_group_receive_tracker.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIR_ROWS    = 25;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 220;
   localparam int STALL_LIMIT = 1000;

   localparam int PHASE_K [PHASES] = '{1, 31, 0, 5, 16, 3, 7, 12};
   localparam int PHASE_N [PHASES] = '{2, 32, 63, 0, 40, 33, 12, 5};

   typedef struct packed {
      logic                 too_short;
      logic [15:0]          grp;
      logic [15:0]          seq;
      logic [7:0]           sym;
      logic [15:0]          size;
      logic                 src;
      logic                 pinned;
      fgrt_pkg::status_type status;
      logic                 deliver;
      logic                 repair;
   } header_row_type;

   // Columns: too_short, group, seq, symbol, size, source, pinned, status, deliver, repair.
   localparam header_row_type DIRECTED_ROWS [DIR_ROWS] = '{
      '{1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1, fgrt_pkg::ST_SHORT, 1'b0, 1'b0},
      '{1'b1, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b0, 1'b1, fgrt_pkg::ST_SHORT, 1'b0, 1'b0},
      '{1'b0, 16'h0000, 16'h0005, 8'h00, 16'h0064, 1'b1, 1'b1, fgrt_pkg::ST_ACCEPTED, 1'b1, 1'b0},
      '{1'b0, 16'h0000, 16'h0003, 8'h00, 16'h0032, 1'b1, 1'b1, fgrt_pkg::ST_DUPLICATE, 1'b0, 1'b0},
      '{1'b0, 16'h0000, 16'h0006, 8'h06, 16'h0001, 1'b1, 1'b1, fgrt_pkg::ST_BAD_SYMBOL, 1'b0, 1'b0},
      '{1'b0, 16'h0000, 16'h0006, 8'hFF, 16'h0001, 1'b1, 1'b1, fgrt_pkg::ST_BAD_SYMBOL, 1'b0, 1'b0},
      '{1'b0, 16'h0000, 16'h0007, 8'h01, 16'h0000, 1'b1, 1'b1, fgrt_pkg::ST_ACCEPTED, 1'b1, 1'b0},
      '{1'b0, 16'h0000, 16'h0008, 8'h01, 16'h0000, 1'b0, 1'b1, fgrt_pkg::ST_ACCEPTED, 1'b0, 1'b0},
      '{1'b0, 16'h0000, 16'h0009, 8'h04, 16'hFFFF, 1'b0, 1'b1, fgrt_pkg::ST_ACCEPTED, 1'b0, 1'b1},
      '{1'b0, 16'h0000, 16'h000A, 8'h02, 16'h0010, 1'b1, 1'b1,
        fgrt_pkg::ST_AFTER_REPAIR, 1'b0, 1'b0},
      '{1'b0, 16'h8000, 16'h0000, 8'h00, 16'h0010, 1'b1, 1'b1, fgrt_pkg::ST_STALE, 1'b1, 1'b0},
      '{1'b0, 16'h8000, 16'h0000, 8'h00, 16'h0010, 1'b0, 1'b1, fgrt_pkg::ST_STALE, 1'b0, 1'b0},
      '{1'b0, 16'h7FFF, 16'h8009, 8'h03, 16'h0000, 1'b1, 1'b0, fgrt_pkg::ST_ACCEPTED, 1'b0, 1'b0},
      '{1'b0, 16'h7FFF, 16'h0000, 8'h05, 16'h0001, 1'b1, 1'b0, fgrt_pkg::ST_ACCEPTED, 1'b0, 1'b0},
      '{1'b0, 16'hFFFF, 16'h0001, 8'h00, 16'h0001, 1'b1, 1'b1, fgrt_pkg::ST_STALE, 1'b1, 1'b0},
      '{1'b0, 16'h8000, 16'hFFFF, 8'h00, 16'h0001, 1'b0, 1'b0, fgrt_pkg::ST_ACCEPTED, 1'b0, 1'b0},
      '{1'b0, 16'h8000, 16'hFFFF, 8'h00, 16'h0000, 1'b0, 1'b1, fgrt_pkg::ST_DUPLICATE, 1'b0, 1'b0},
      '{1'b0, 16'h8000, 16'h0000, 8'h01, 16'h0002, 1'b1, 1'b0, fgrt_pkg::ST_ACCEPTED, 1'b0, 1'b0},
      '{1'b0, 16'h8000, 16'h0001, 8'h02, 16'h0003, 1'b1, 1'b0, fgrt_pkg::ST_ACCEPTED, 1'b0, 1'b0},
      '{1'b0, 16'h8000, 16'h0002, 8'h03, 16'h0004, 1'b1, 1'b0, fgrt_pkg::ST_ACCEPTED, 1'b0, 1'b0},
      '{1'b0, 16'h8000, 16'h0003, 8'h05, 16'h0005, 1'b0, 1'b0, fgrt_pkg::ST_ACCEPTED, 1'b0, 1'b0},
      '{1'b0, 16'h8001, 16'h0004, 8'h04, 16'h0001, 1'b0, 1'b0, fgrt_pkg::ST_ACCEPTED, 1'b0, 1'b0},
      '{1'b0, 16'h8001, 16'h0005, 8'h05, 16'h0001, 1'b0, 1'b0, fgrt_pkg::ST_ACCEPTED, 1'b0, 1'b0},
      '{1'b0, 16'h8001, 16'h0006, 8'h00, 16'h0001, 1'b1, 1'b0, fgrt_pkg::ST_ACCEPTED, 1'b0, 1'b0},
      '{1'b0, 16'h8001, 16'h0007, 8'h01, 16'h0001, 1'b1, 1'b1, fgrt_pkg::ST_ACCEPTED, 1'b1, 1'b1}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;  // header_group, header_seq, header_symbol, payload_size
   logic [1:0]  req_tuser = '0;  // too_short, is_source
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;       // deliver_source, repair_request, present_mask,
                                 // longest_size, highest_seq_out, zero fill
   logic [2:0]  rsp_tuser;       // status
   logic        csr_we = 1'b0;
   logic [0:0]  csr_addr = '0;
   logic [5:0]  csr_wdata = '0;

   header_row_type       req_row = '0;
   header_row_type       header_q [$];
   fgrt_pkg::result_type outcome_q [$];

   bit          calm = 1'b0;
   int          mismatches = 0;
   int          quiet_cycles = 0;
   logic [15:0] grp_cursor = '0;
   logic [15:0] seq_run = '0;

   logic [4:0]  cfg_k;
   logic [5:0]  cfg_n;
   logic [15:0] cur_group;
   logic [15:0] top_seq;
   logic [31:0] seen_mask;
   logic [31:0] filled_mask;
   logic [7:0]  sym_count;
   logic        repaired;
   logic [15:0] max_len;

   fec_group_receive_tracker DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic seq_older(logic [15:0] a, logic [15:0] b);
      logic [15:0] d;
      d = a - b;
      return d[15];
   endfunction

   function automatic fgrt_pkg::result_type track_header(header_row_type h);
      fgrt_pkg::result_type r;
      logic [5:0]           n_eff;
      logic [31:0]          need;
      logic [31:0]          sym_bit;
      r = '0;
      n_eff = (cfg_n > 6'(fgrt_pkg::MAX_SYMBOLS)) ? 6'(fgrt_pkg::MAX_SYMBOLS) : cfg_n;
      need = (cfg_k == 5'd0) ? 32'd0 : ((32'd1 << cfg_k) - 32'd1);
      sym_bit = 32'd1 << h.sym[4:0];
      if (h.too_short) begin
         r.status = fgrt_pkg::ST_SHORT;
      end else if (h.grp != cur_group && seq_older(h.grp, cur_group)) begin
         r.status = fgrt_pkg::ST_STALE;
         r.deliver_source = h.src;
      end else begin
         if (h.grp != cur_group) begin
            cur_group = h.grp;
            seen_mask = '0;
            filled_mask = '0;
            sym_count = '0;
            repaired = 1'b0;
            max_len = '0;
         end
         if (h.sym >= {2'b00, n_eff}) begin
            r.status = fgrt_pkg::ST_BAD_SYMBOL;
         end else if (repaired) begin
            r.status = fgrt_pkg::ST_AFTER_REPAIR;
         end else begin
            if (seq_older(top_seq, h.seq)) top_seq = h.seq;
            if ((filled_mask & sym_bit) != 0) begin
               r.status = fgrt_pkg::ST_DUPLICATE;
            end else begin
               if (h.size > max_len) max_len = h.size;
               if (h.size != 0) filled_mask |= sym_bit;
               seen_mask |= sym_bit;
               if (sym_count != 8'hFF) sym_count++;
               r.deliver_source = h.src;
               if (sym_count >= {3'b000, cfg_k} && (seen_mask & need) != need) begin
                  r.repair_request = 1'b1;
                  repaired = 1'b1;
               end
            end
         end
      end
      r.present_mask = seen_mask;
      r.longest_size = max_len;
      r.highest_seq_out = top_seq;
      return r;
   endfunction

   task automatic load_config(logic [4:0] k, logic [5:0] n);
      csr_we <= 1'b1;
      csr_addr <= fgrt_pkg::CSR_SOURCE_COUNT;
      csr_wdata <= {1'b0, k};
      @(posedge clock);
      csr_addr <= fgrt_pkg::CSR_BLOCK_COUNT;
      csr_wdata <= n;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_k = k;
      cfg_n = n;
   endtask

   task automatic send_headers();
      header_row_type h;
      while (header_q.size() > 0) begin
         if (!calm && $urandom_range(99) < 15) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end else begin
            h = header_q.pop_front();
            req_row <= h;
            req_tdata <= {h.size, h.sym, h.seq, h.grp};
            req_tuser <= {h.src, h.too_short};
            req_tvalid <= 1'b1;
            do @(posedge clock); while (!req_tready);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drain();
      @(posedge clock);
      while (outcome_q.size() != 0) @(posedge clock);
   endtask

   task automatic build_phase(int quota);
      header_row_type h;
      int order [32];
      int n_eff, span, made, roll, j, t;
      made = 0;
      n_eff = (cfg_n > fgrt_pkg::MAX_SYMBOLS) ? fgrt_pkg::MAX_SYMBOLS : int'(cfg_n);
      span = (n_eff == 0) ? 4 : n_eff;
      while (made < quota) begin
         if ($urandom_range(99) < 85) grp_cursor += 16'd1;
         else grp_cursor += 16'($urandom_range(32767, 1));
         for (int i = 0; i < 32; i++) order[i] = i;
         for (int i = n_eff - 1; i > 0; i--) begin
            j = $urandom_range(i, 0);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
         end
         for (int i = 0; i < span && made < quota; i++) begin
            roll = $urandom_range(99);
            h = '0;
            h.grp = grp_cursor;
            h.seq = seq_run;
            h.sym = 8'(order[i]);
            t = $urandom_range(99);
            h.size = (t < 20) ? 16'h0000 : (t < 25) ? 16'hFFFF : 16'($urandom_range(65535, 1));
            h.src = ($urandom_range(9) != 0) ? (order[i] < cfg_k) : 1'($urandom);
            seq_run += ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(3, 1));
            if (roll < 4) begin
               h.too_short = 1'b1;
               h.grp = 16'($urandom);
               h.seq = 16'($urandom);
               h.sym = 8'($urandom);
               h.src = 1'($urandom);
            end else if (roll < 8) begin
               h.grp = grp_cursor - 16'($urandom_range(32768, 1));
            end else if (roll < 12) begin
               h.sym = 8'($urandom_range(255, n_eff));
            end
            if (roll < 12 || roll >= 20) begin
               header_q.push_back(h);
               made++;
            end
            if (roll >= 20 && roll < 26) begin
               h.size = 16'($urandom);
               header_q.push_back(h);
               made++;
            end
         end
      end
   endtask

   always @(posedge clock) begin : accept_side
      fgrt_pkg::result_type r;
      if (!reset && req_tvalid && req_tready) begin
         r = track_header(req_row);
         if (req_row.pinned) begin
            r.status = req_row.status;
            r.deliver_source = req_row.deliver;
            r.repair_request = req_row.repair;
         end
         outcome_q.push_back(r);
      end
   end

   always @(posedge clock) begin : response_side
      fgrt_pkg::result_type want;
      fgrt_pkg::result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = fgrt_pkg::status_type'(rsp_tuser);
         got.deliver_source = rsp_tdata[0];
         got.repair_request = rsp_tdata[1];
         got.present_mask = rsp_tdata[33:2];
         got.longest_size = rsp_tdata[49:34];
         got.highest_seq_out = rsp_tdata[65:50];
         if (outcome_q.size() == 0) begin
            if (mismatches < 10)
               $display("%t: response with none pending: status %0d data %h",
                        $realtime, rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = outcome_q.pop_front();
            if (got !== want) begin
               if (mismatches < 10) begin
                  $display("%t: expected status %0d deliver %b repair %b mask %h size %h seq %h",
                           $realtime, want.status, want.deliver_source, want.repair_request,
                           want.present_mask, want.longest_size, want.highest_seq_out);
                  $display("%t: actual   status %0d deliver %b repair %b mask %h size %h seq %h",
                           $realtime, got.status, got.deliver_source, got.repair_request,
                           got.present_mask, got.longest_size, got.highest_seq_out);
               end
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 15);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      cfg_k = fgrt_pkg::K_RESET;
      cfg_n = fgrt_pkg::N_RESET;
      cur_group = '0;
      top_seq = '0;
      seen_mask = '0;
      filled_mask = '0;
      sym_count = '0;
      repaired = 1'b0;
      max_len = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIR_ROWS; i++) header_q.push_back(DIRECTED_ROWS[i]);
      send_headers();
      wait_drain();
      grp_cursor = 16'h8001;
      seq_run = 16'h0008;
      for (int p = 0; p < PHASES; p++) begin
         calm = (p == 1);
         load_config(5'(PHASE_K[p]), 6'(PHASE_N[p]));
         build_phase(PHASE_ITEMS);
         send_headers();
         wait_drain();
      end
      calm = 1'b0;
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* fec_group_receive_tracker.f */
src/fgrt_pkg.sv
src/fgrt_step.sv
src/fec_group_receive_tracker.sv
tb/tb_top.sv
